// ===== sv/rsh_pkg.sv =====
package rsh_pkg;

    localparam int BIN_COUNT = 100;
    localparam int BIN_W = $clog2(BIN_COUNT);
    localparam int IDX_W = 7;
    localparam int CNT_W = 20;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [16:0] TWO_LN2_Q16 = 17'd90852;
    localparam logic [15:0] SIGMA_RST = 16'd8192;
    localparam logic [15:0] BPU_RST = 16'd2560;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_READ = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic REG_SIGMA = 1'b0;
    localparam logic REG_BPU = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATH,
        ST_RDWAIT,
        ST_UPDATE,
        ST_DIV,
        ST_CLEAR,
        ST_DONE
    } t_state;

    // Sequencer of the shared arithmetic unit
    typedef enum logic [2:0] {
        M_IDLE,
        M_NORM,
        M_LOG,
        M_MUL,
        M_SQRT,
        M_SCALE1,
        M_SCALE2,
        M_DONE
    } t_mstate;

    // Shared arithmetic unit control
    typedef struct packed {
        logic start;
        logic [23:0] uniform;
        logic [15:0] sigma;
        logic [15:0] bpu;
    } t_math_req;

    typedef struct packed {
        logic done;
        logic [35:0] raw_hi; // raw bin before range check (upper bits kept)
    } t_math_rsp;

endpackage

// ===== sv/rsh_ram.sv =====
module rsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/rsh_math.sv =====
module rsh_math
    import rsh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_math_req i_req,
    output t_math_rsp o_rsp
);
    t_mstate r_st, n_st;
    logic [24:0] r_x, n_x;
    logic [4:0]  r_e, n_e;
    logic [4:0]  r_cnt, n_cnt;
    logic [15:0] r_frac, n_frac;
    logic [37:0] r_v, n_v;
    logic [37:0] r_res, n_res;
    logic [37:0] r_bit, n_bit;
    logic [35:0] r_raw, n_raw;
    logic [34:0] r_prod, n_prod;
    logic [15:0] r_sig, n_sig;
    logic [15:0] r_bpu, n_bpu;

    logic [49:0] sq;
    logic [21:0] nlog;
    logic [38:0] tprod;
    logic [37:0] trial;

    always_comb begin
        sq = 50'(r_x) * 50'(r_x);
        nlog = (22'(5'd24 - r_e) << 16) - 22'(r_frac);
        tprod = 39'(nlog) * 39'(TWO_LN2_Q16);
        trial = r_res + r_bit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= M_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_x <= n_x; r_e <= n_e; r_cnt <= n_cnt; r_frac <= n_frac;
        r_v <= n_v; r_res <= n_res; r_bit <= n_bit; r_raw <= n_raw;
        r_prod <= n_prod; r_sig <= n_sig; r_bpu <= n_bpu;
    end

    always_comb begin
        n_st = r_st; n_x = r_x; n_e = r_e; n_cnt = r_cnt; n_frac = r_frac;
        n_v = r_v; n_res = r_res; n_bit = r_bit; n_raw = r_raw;
        n_prod = r_prod; n_sig = r_sig; n_bpu = r_bpu;
        case (r_st)
            M_IDLE: begin
                if (i_req.start) begin
                    n_x = {1'b0, (i_req.uniform == '0) ? 24'd1 : i_req.uniform};
                    n_e = 5'd23;
                    n_sig = i_req.sigma;
                    n_bpu = i_req.bpu;
                    n_frac = '0;
                    n_cnt = '0;
                    n_st = M_NORM;
                end
            end
            // normalize one bit position a cycle
            M_NORM: begin
                if (r_x[23] || r_e == '0) begin
                    n_st = M_LOG;
                end else begin
                    n_x = r_x << 1;
                    n_e = r_e - 5'd1;
                end
            end
            M_LOG: begin
                n_frac = {r_frac[14:0], sq[47]};
                n_x = sq[47] ? sq[47:23] >> 1 : sq[47:23];
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    n_st = M_MUL;
                end
            end
            M_MUL: begin
                n_v = {tprod[37:16], 16'd0};
                n_res = '0;
                n_bit = 38'd1 << 36;
                n_st = M_SQRT;
            end
            M_SQRT: begin
                if (r_v >= trial) begin
                    n_v = r_v - trial;
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_st = M_SCALE1;
                end
            end
            M_SCALE1: begin
                n_prod = 35'(r_res[18:0]) * 35'(r_sig);
                n_st = M_SCALE2;
            end
            M_SCALE2: begin
                n_raw = 36'((51'(r_prod) * 51'(r_bpu)) >> 36);
                n_st = M_DONE;
            end
            M_DONE: n_st = M_IDLE;
            default: n_st = M_IDLE;
        endcase
    end

    assign o_rsp.done = (r_st == M_DONE);
    assign o_rsp.raw_hi = r_raw;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == M_DONE) |=> (r_st == M_IDLE)) else $error("math done not one cycle");
    a_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == M_LOG) |-> (r_x[23] || r_e == '0)) else $error("log entered unnormalized");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == M_LOG) |-> (r_cnt <= 5'd15)) else $error("log count overrun");
endmodule

// ===== sv/rsh_div.sv =====
module rsh_div
    import rsh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [39:0] i_num,
    input  logic [CNT_W-1:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quot
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_cnt, n_cnt;
    logic [39:0] r_num, n_num;
    logic [19:0] r_rem, n_rem;
    logic [39:0] r_q, n_q;
    logic [CNT_W-1:0] r_den, n_den;
    logic [20:0] shifted;

    assign shifted = {r_rem, r_num[39]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt; r_num <= n_num; r_rem <= n_rem; r_q <= n_q; r_den <= n_den;
    end

    // restoring divide, one quotient bit a cycle
    always_comb begin
        n_busy = r_busy; n_done = 1'b0; n_cnt = r_cnt; n_num = r_num;
        n_rem = r_rem; n_q = r_q; n_den = r_den;
        if (i_start) begin
            n_busy = 1'b1; n_cnt = '0; n_num = i_num; n_rem = '0; n_q = '0; n_den = i_den;
        end else if (r_busy) begin
            n_num = r_num << 1;
            if (shifted >= 21'(r_den)) begin
                n_rem = 20'(shifted - 21'(r_den));
                n_q = {r_q[38:0], 1'b1};
            end else begin
                n_rem = shifted[19:0];
                n_q = {r_q[38:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd39) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_q[39:16] != '0) ? 16'hFFFF : r_q[15:0];

    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("div done while busy");
endmodule

// ===== sv/rayleigh_sample_histogram.sv =====
// Rayleigh sampler with a 100-bin histogram; one request at a time, o_valid follows busy.
// Sample: busy through normalize, log, sqrt, scale, bin update, divide and done; the
// result strobe comes in the same cycle that busy falls.
// Read: busy while the 40-step divider runs; clear and unused commands do not divide.
// With a zero total the divide is skipped. The receiver cannot stall.
// Synchronous active-low reset restores sigma=2.0, bins_per_unit=10.0 and drops all valid bits.
module rayleigh_sample_histogram
    import rsh_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_command,
    input  logic [23:0]      i_uniform,
    input  logic [6:0]       i_bin_select,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [15:0]      i_cfg_wdata,
    output logic             o_valid,
    output logic [IDX_W-1:0] o_bin_index,
    output logic             o_in_range,
    output logic [CNT_W-1:0] o_bin_count,
    output logic [15:0]      o_density
);
    t_state r_state, n_state;
    logic [15:0] r_sigma, r_bpu;
    logic [CNT_W-1:0] r_total, n_total;
    logic [BIN_COUNT-1:0] r_vld, n_vld;
    logic [1:0] r_cmd, n_cmd;
    logic [BIN_W-1:0] r_idx, n_idx;
    logic r_inr, n_inr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [15:0] r_dens, n_dens;
    logic r_valid, n_valid;
    logic r_first_div;

    t_math_req math_req;
    t_math_rsp math_rsp;
    logic div_start, div_done;
    logic [15:0] div_q;
    logic ram_we;
    logic [BIN_W-1:0] ram_waddr;
    logic [CNT_W-1:0] ram_wdata, ram_rdata, cur_cnt;
    logic accept;

    assign accept = start && !busy;
    assign busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma <= SIGMA_RST;
            r_bpu <= BPU_RST;
        end else if (i_cfg_we) begin
            // hold sigma or bin factor as written
            if (i_cfg_index == REG_SIGMA) r_sigma <= i_cfg_wdata;
            else r_bpu <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_total <= '0;
            r_vld <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_vld <= n_vld;
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd; r_idx <= n_idx; r_inr <= n_inr; r_cnt <= n_cnt;
        r_dens <= n_dens;
    end

    // mark the first divide cycle so the divider starts once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_first_div <= 1'b0;
        else r_first_div <= (r_state == ST_UPDATE);
    end

    assign math_req.start = (r_state == ST_IDLE) && accept && (i_command == CMD_SAMPLE);
    assign math_req.uniform = i_uniform;
    assign math_req.sigma = r_sigma;
    assign math_req.bpu = r_bpu;

    rsh_math u_math (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(math_req), .o_rsp(math_rsp)
    );

    rsh_ram #(.WIDTH(CNT_W), .DEPTH(BIN_COUNT)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(n_idx), .o_rdata(ram_rdata)
    );

    // invalid bins read as zero
    assign cur_cnt = r_vld[r_idx] ? ram_rdata : '0;

    // numerator count * bins_per_unit * 16
    rsh_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num({36'(r_cnt) * 36'(r_bpu), 4'd0}),
        .i_den(r_total), .o_done(div_done), .o_quot(div_q)
    );

    always_comb begin
        n_state = r_state; n_total = r_total; n_vld = r_vld; n_valid = 1'b0;
        n_cmd = r_cmd; n_idx = r_idx; n_inr = r_inr; n_cnt = r_cnt; n_dens = r_dens;
        div_start = 1'b0;
        ram_we = 1'b0; ram_waddr = r_idx; ram_wdata = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cmd = i_command;
                    n_inr = 1'b0; n_cnt = '0; n_dens = '0;
                    n_idx = (i_bin_select >= 7'(BIN_COUNT)) ? BIN_W'(BIN_COUNT - 1)
                                                          : BIN_W'(i_bin_select);
                    case (i_command)
                        CMD_SAMPLE: n_state = ST_MATH;
                        CMD_READ:   n_state = ST_RDWAIT;
                        CMD_CLEAR:  n_state = ST_CLEAR;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_MATH: begin
                if (math_rsp.done) begin
                    if (math_rsp.raw_hi < 36'(BIN_COUNT)) begin
                        n_idx = BIN_W'(math_rsp.raw_hi);
                        n_inr = 1'b1;
                    end else begin
                        n_idx = BIN_W'(BIN_COUNT - 1);
                    end
                    n_state = ST_RDWAIT;
                end
            end
            ST_RDWAIT: n_state = ST_UPDATE;
            ST_UPDATE: begin
                // bump count and total on an in-range sample
                if (r_inr) begin
                    n_cnt = (cur_cnt != COUNT_MAX) ? cur_cnt + 1'b1 : cur_cnt;
                    ram_we = 1'b1; ram_wdata = n_cnt;
                    n_vld[r_idx] = 1'b1;
                    if (r_total != COUNT_MAX) n_total = r_total + 1'b1;
                end else begin
                    n_cnt = cur_cnt;
                end
                n_state = ST_DIV;
            end
            ST_DIV: begin
                // skip the divide on an empty histogram
                div_start = (r_total != '0) && r_first_div;
                if (r_total == '0) begin
                    n_dens = '0;
                    n_state = ST_DONE;
                end else if (div_done) begin
                    n_dens = div_q;
                    n_state = ST_DONE;
                end
            end
            ST_CLEAR: begin
                // drop valid bits and total at once
                n_vld = '0;
                n_total = '0;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid = r_valid;
    assign o_bin_index = IDX_W'(r_idx) & {IDX_W{r_cmd == CMD_SAMPLE || r_cmd == CMD_READ}};
    assign o_in_range = r_inr;
    assign o_bin_count = r_cnt;
    assign o_density = r_dens;

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("double result");
    a_inr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_in_range) |-> (o_bin_count != '0)) else $error("in range empty bin");
endmodule
